// ===== src/slfr_pkg.sv =====
// Shared types and constants for the sync/length frame receiver.
// Used by the frame tracker, the top level and the port checker; no dependencies.
package slfr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned PHASE_W = 3;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned REPLY_LEN = 5;
   localparam int unsigned REPLY_IDX_W = 3;

   localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hE0;

   // Frame phases
   localparam logic [PHASE_W-1:0] PH_HUNT    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_LEN_HI  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LEN_LO  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
   localparam logic [PHASE_W-1:0] PH_SUM     = 3'd4;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
   localparam logic [KIND_W-1:0] KIND_GOOD    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_BAD_SUM = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_LEN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REPLY   = 3'd4;

   typedef struct packed {
      logic              valid;   // this byte causes a result
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              reply;   // failure reply burst follows
   } slfr_result_type;

   // Checksum failure reply frame E0 00 02 03 05
   function automatic logic [BYTE_W-1:0] reply_byte(input logic [REPLY_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         3'd0:    b = 8'hE0;
         3'd1:    b = 8'h00;
         3'd2:    b = 8'h02;
         3'd3:    b = 8'h03;
         3'd4:    b = 8'h05;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== src/slfr_frame.sv =====
// Frame tracker: phase, length, byte count and running checksum of the frame.
// Decodes the result caused by the presented byte; depends on slfr_pkg.
module slfr_frame (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [slfr_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                          reply_enable,
   output slfr_pkg::slfr_result_type     result
);
   import slfr_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  len_high_ff, len_high_in;
   logic [LEN_W-1:0]   bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [LEN_W-1:0]   len;

   assign len = {len_high_ff, rx_byte};

   always_comb begin
      phase_in      = phase_ff;
      len_high_in   = len_high_ff;
      bytes_left_in = bytes_left_ff;
      sum_in        = sum_ff;
      result        = '0;
      unique case (phase_ff)
         PH_LEN_HI: begin
            len_high_in = rx_byte;
            sum_in      = rx_byte;
            phase_in    = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            sum_in = sum_ff + rx_byte;
            if (len == '0) begin
               result.valid = 1'b1;
               result.kind  = KIND_BAD_LEN;
               result.last  = 1'b1;
               phase_in     = PH_HUNT;
            end else begin
               bytes_left_in = len - 1'b1;
               phase_in      = (len == LEN_W'(1)) ? PH_SUM : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            sum_in        = sum_ff + rx_byte;
            result.valid  = 1'b1;
            result.kind   = KIND_PAYLOAD;
            result.data   = rx_byte;
            result.last   = 1'b1;
            bytes_left_in = bytes_left_ff - 1'b1;
            if (bytes_left_ff == LEN_W'(1)) phase_in = PH_SUM;
         end
         PH_SUM: begin
            result.valid = 1'b1;
            if (rx_byte == sum_ff) begin
               result.kind = KIND_GOOD;
               result.last = 1'b1;
            end else begin
               result.kind  = KIND_BAD_SUM;
               result.last  = ~reply_enable;
               result.reply = reply_enable;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            // hunting, and the unused codes behave alike
            phase_in = (rx_byte == SYNC_BYTE) ? PH_LEN_HI : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         len_high_ff   <= '0;
         bytes_left_ff <= '0;
         sum_ff        <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         len_high_ff   <= len_high_in;
         bytes_left_ff <= bytes_left_in;
         sum_ff        <= sum_in;
      end
   end

endmodule

// ===== src/sync_length_frame_receiver.sv =====
// Top level of the sync/length frame receiver: input register, frame tracker,
// reply sequencer and result register. Depends on slfr_pkg and slfr_frame.
// An accepted byte is held in the input register; its result is registered in the result register and offered on rsp.
// Throughput: one byte per cycle while rsp does not stall; a bad checksum with the reply enabled holds
// the input while the five reply bytes go out of the result register.
// Reset (synchronous, active high) returns to sync hunting, empties both
// registers and sets reply_enable to one.
module sync_length_frame_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] rx_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [7:0] out_byte
   output logic [slfr_pkg::KIND_W-1:0]   rsp_tuser,   // [2:0] out_kind
   output logic                          rsp_tlast,   // out_last
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data  // reply_enable
);
   import slfr_pkg::*;

   logic                   reply_enable_ff;
   logic                   in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]      in_byte_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [KIND_W-1:0]      out_kind_ff, out_kind_in;
   logic [BYTE_W-1:0]      out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;
   logic [REPLY_IDX_W-1:0] reply_cnt_ff, reply_cnt_in;   // 0: idle, n: send reply byte n-1
   logic                   out_free;
   logic                   step;
   slfr_result_type        result;

   slfr_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (in_byte_ff),
      .reply_enable (reply_enable_ff),
      .result       (result)
   );

   assign out_free   = ~out_valid_ff | rsp_tready;
   // advance the held byte once no reply is going out and its result, if any, has somewhere to go
   assign step       = in_valid_ff & (reply_cnt_ff == '0) & (out_free | ~result.valid);
   assign req_tready = ~in_valid_ff | step;

   always_comb begin
      in_valid_in  = req_tvalid | (in_valid_ff & ~step);
      if (req_tready) in_valid_in = req_tvalid;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      reply_cnt_in = reply_cnt_ff;
      if (out_free) begin
         if (reply_cnt_ff != '0) begin
            out_valid_in = 1'b1;
            out_kind_in  = KIND_REPLY;
            out_byte_in  = reply_byte(reply_cnt_ff - 1'b1);
            out_last_in  = (reply_cnt_ff == REPLY_IDX_W'(REPLY_LEN));
            reply_cnt_in = (reply_cnt_ff == REPLY_IDX_W'(REPLY_LEN)) ? '0
                                                                       : reply_cnt_ff + 1'b1;
         end else if (step && result.valid) begin
            out_valid_in = 1'b1;
            out_kind_in  = result.kind;
            out_byte_in  = result.data;
            out_last_in  = result.last;
            if (result.reply) reply_cnt_in = REPLY_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_enable_ff <= 1'b1;
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         reply_cnt_ff    <= '0;
      end else begin
         if (csr_write_enable) reply_enable_ff <= csr_write_data;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         reply_cnt_ff <= reply_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) in_byte_ff <= req_tdata;
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== src/slfr_checker.sv =====
// Port checker for the sync/length frame receiver, bound to the top level.
// Depends on slfr_pkg.
module slfr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [7:0]                  rsp_tdata,
   input logic [slfr_pkg::KIND_W-1:0] rsp_tuser,
   input logic                        rsp_tlast
);
   import slfr_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_GOOD || rsp_tuser == KIND_BAD_SUM
         || rsp_tuser == KIND_BAD_LEN) |-> rsp_tdata == 8'h00)
      else $error("status result carries data");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_PAYLOAD || rsp_tuser == KIND_GOOD
         || rsp_tuser == KIND_BAD_LEN) |-> rsp_tlast)
      else $error("single result without last");

   // reply burst starts with the sync byte right after an open bad-checksum status
   a_reply_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == KIND_BAD_SUM && !rsp_tlast |=>
         rsp_tvalid && rsp_tuser == KIND_REPLY && rsp_tdata == SYNC_BYTE)
      else $error("reply burst missing");

endmodule

bind sync_length_frame_receiver slfr_checker u_slfr_checker (.*);
